// ----- rtl/core/stq_pkg.sv -----
// Shared codes and constants for the sleep timer queue.
package stq_pkg;

  localparam int TICK_W      = 32;
  localparam int TARGET_W    = 8;
  localparam int MAX_RESULTS = 16;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_SLEEP = 2'd2;

  localparam logic [1:0] KIND_WAKE = 2'd0;
  localparam logic [1:0] KIND_TIME = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

endpackage

// ----- rtl/core/sleep_timer_queue.sv -----
// Sleep timer queue: tick counter and a wake-time ordered table of sleepers.
// S_REPLY loads the result of a time query or table-full request once the output is free.
// A tick scans entries through S_TRD and S_TCMP until one is not due, then ends in S_TEND.
// A sleep request walks S_IRD and S_ICMP, moving later entries up one slot to open its slot.
// One request is in work at a time; a result may still wait at the output when the next
// is taken. Reset clears tick count, fill count and head pointer; the table RAM is not swept.
module sleep_timer_queue import stq_pkg::*; #(
  parameter int MAX_SLEEPERS = 16,
  parameter int ID_BITS      = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  input  logic [7:0]          requester,
  input  logic [31:0]         duration,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          kind,
  output logic [TARGET_W-1:0] target,
  output logic [TICK_W-1:0]   time_value,
  output logic                last
);

  localparam int CNT_W    = $clog2(MAX_SLEEPERS + 1);
  localparam int ADDR_W   = (MAX_SLEEPERS > 1) ? $clog2(MAX_SLEEPERS) : 1;
  localparam int RAM_D    = 1 << ADDR_W;
  localparam int ENTRY_W  = TICK_W + ID_BITS;
  localparam int LIMIT    = (MAX_SLEEPERS < MAX_RESULTS) ? MAX_SLEEPERS : MAX_RESULTS;
  localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);
  localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(MAX_SLEEPERS);

  typedef enum logic [2:0] {
    S_IDLE, S_REPLY, S_TRD, S_TCMP, S_TEND, S_IRD, S_ICMP
  } state_t;

  state_t              state;
  logic [TICK_W-1:0]   tick_count;
  logic [TICK_W-1:0]   key;          // deadline of a new sleeper, or the new count on a tick
  logic [CNT_W-1:0]    entry_count;
  logic [ADDR_W-1:0]   head;         // physical slot of the earliest deadline
  logic [CNT_W-1:0]    pos;          // walk position, shared by tick scan and insert
  logic [ID_BITS-1:0]  req_id;
  logic [ID_BITS-1:0]  pend_id;      // due sleeper held back until we know if it is the last
  logic                have_pend;
  logic [1:0]          reply_kind;

  logic                out_free;
  logic                out_load;
  logic [TICK_W-1:0]   sum;
  logic [ID_BITS+7:0]  req_ext;
  logic [ID_BITS+7:0]  pend_ext;
  logic [ID_BITS+7:0]  reqo_ext;
  logic [ENTRY_W-1:0]  rdata;
  logic [TICK_W-1:0]   rd_wake;
  logic                rd_due;
  logic [CNT_W-1:0]    rd_log;
  logic [ADDR_W-1:0]   raddr;
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [ENTRY_W-1:0]  wdata;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // A new result goes into the output register this cycle.
  assign out_load = out_free && ((state == S_REPLY) || (state == S_TEND) ||
                                 (state == S_TCMP && rd_due && have_pend));

  // One adder serves both the tick increment and the deadline sum.
  assign sum = tick_count + ((mode == MODE_TICK) ? TICK_W'(1) : duration);

  // Mailbox ids are kept in ID_BITS and shown on the 8-bit target port.
  assign req_ext  = {{ID_BITS{1'b0}}, requester};
  assign pend_ext = {8'd0, pend_id};
  assign reqo_ext = {8'd0, req_id};

  // One compare unit: table entry against the key.
  assign rd_wake = rdata[ENTRY_W-1:ID_BITS];
  assign rd_due  = (rd_wake <= key);

  // Insert looks one slot below pos, tick scan looks at pos itself.
  assign rd_log = (state == S_IRD || state == S_ICMP) ? pos - CNT_W'(1) : pos;
  assign raddr  = head + rd_log[ADDR_W-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = head + pos[ADDR_W-1:0];
    wdata = {key, req_id};
    unique case (state)
      S_IRD: begin
        we = (pos == '0);
      end
      S_ICMP: begin
        we = 1'b1;
        if (!rd_due) begin
          wdata = rdata;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  stq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_D)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      tick_count  <= '0;
      entry_count <= '0;
      head        <= '0;
      have_pend   <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_id <= req_ext[ID_BITS-1:0];
            key    <= sum;
            unique case (mode)
              MODE_TICK: begin
                tick_count <= sum;
                pos        <= '0;
                have_pend  <= 1'b0;
                state      <= S_TRD;
              end
              MODE_QUERY: begin
                reply_kind <= KIND_TIME;
                state      <= S_REPLY;
              end
              MODE_SLEEP: begin
                if (entry_count >= FULL_C) begin
                  reply_kind <= KIND_FULL;
                  state      <= S_REPLY;
                end else begin
                  pos   <= entry_count;
                  state <= S_IRD;
                end
              end
              default: begin
                state <= S_IDLE;   // unused mode: dropped
              end
            endcase
          end
        end
        S_REPLY: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            kind       <= reply_kind;
            target     <= reqo_ext[7:0];
            time_value <= (reply_kind == KIND_TIME) ? tick_count : '0;
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_TRD: begin
          // read of slot pos is in flight this cycle
          if (pos < entry_count && pos < LIMIT_C) begin
            state <= S_TCMP;
          end else begin
            state <= S_TEND;
          end
        end
        S_TCMP: begin
          if (!rd_due) begin
            state <= S_TEND;
          end else if (!have_pend || out_free) begin
            if (have_pend) begin
              out_valid  <= 1'b1;
              kind       <= KIND_WAKE;
              target     <= pend_ext[7:0];
              time_value <= '0;
              last       <= 1'b0;
            end
            pend_id   <= rdata[ID_BITS-1:0];
            have_pend <= 1'b1;
            pos       <= pos + CNT_W'(1);
            state     <= S_TRD;
          end
        end
        S_TEND: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            kind        <= have_pend ? KIND_WAKE : KIND_NONE;
            target      <= have_pend ? pend_ext[7:0] : 8'd0;
            time_value  <= '0;
            last        <= 1'b1;
            head        <= head + pos[ADDR_W-1:0];
            entry_count <= entry_count - pos;
            state       <= S_IDLE;
          end
        end
        S_IRD: begin
          if (pos == '0) begin
            entry_count <= entry_count + CNT_W'(1);
            state       <= S_IDLE;
          end else begin
            state <= S_ICMP;
          end
        end
        S_ICMP: begin
          // equal deadlines stay ahead of the newcomer
          if (rd_due) begin
            entry_count <= entry_count + CNT_W'(1);
            state       <= S_IDLE;
          end else begin
            pos   <= pos - CNT_W'(1);
            state <= S_IRD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/stq_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
module stq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
